@@ src/acr_pkg.sv @@
// Shared types, constants and the median-of-three function for the
// channel rotator with median filtering. No dependencies.
package acr_pkg;

	// Fixed field widths
	localparam int SAMPLE_W        = 10;
	localparam int MUX_W           = 3;
	localparam int CHAN_W          = 3;
	localparam int SLOT_W          = 2;
	localparam int SLOTS           = 3;
	localparam int MEDIAN_CHANNELS = 3;

	localparam logic [MUX_W-1:0]  MUX_BASE  = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_LAST = 2'(SLOTS - 1);

	// Store write request from the scan control
	typedef struct packed {
		logic              en;
		logic [CHAN_W-1:0] chan;
		logic [SLOT_W-1:0] slot;
	} acr_wr_t;

	// Scan state after the current item has been applied
	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic              kept;
		logic              all_filled;
	} acr_status_t;

	// Median of three: max(min(a,b), min(max(a,b),c))
	function automatic logic [SAMPLE_W-1:0] med3(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c
	);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [SAMPLE_W-1:0] hc;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		hc = (hi < c) ? hi : c;
		return (lo > hc) ? lo : hc;
	endfunction

endpackage

@@ src/acr_scan_ctrl.sv @@
// Channel scan sequencer: settle discard, slot and channel counters,
// ready flag. Depends on acr_pkg.
module acr_scan_ctrl import acr_pkg::*; #(
	parameter int CHANNEL_COUNT = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	output acr_wr_t     wr,
	output acr_status_t status
);

	localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(CHANNEL_COUNT - 1);

	logic [CHAN_W-1:0] chan_q, chan_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic              discard_q, discard_d;
	logic              all_q, all_d;

	// Next scan state: drop one item after a switch, then fill three slots
	always_comb begin
		chan_d    = chan_q;
		slot_d    = slot_q;
		discard_d = discard_q;
		all_d     = all_q;
		if (discard_q) begin
			discard_d = 1'b0;
		end else if (slot_q == SLOT_LAST) begin
			slot_d    = '0;
			discard_d = 1'b1;
			if (chan_q == CHAN_LAST) begin
				chan_d = '0;
				all_d  = 1'b1;
			end else begin
				chan_d = chan_q + 1'b1;
			end
		end else begin
			slot_d = slot_q + 1'b1;
		end
	end

	// Store write and result status
	always_comb begin
		wr.en             = !discard_q;
		wr.chan           = chan_q;
		wr.slot           = slot_q;
		status.chan       = chan_d;
		status.kept       = !discard_q;
		status.all_filled = all_d;
	end

	// Advance on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q    <= '0;
			slot_q    <= '0;
			discard_q <= 1'b1;
			all_q     <= 1'b0;
		end else if (advance) begin
			chan_q    <= chan_d;
			slot_q    <= slot_d;
			discard_q <= discard_d;
			all_q     <= all_d;
		end
	end

	a_switch_discards: assert property (@(posedge clk) disable iff (!arst_n)
		(chan_q != $past(chan_q)) |-> discard_q)
		else $error("channel switch without settle discard");

	a_discard_at_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		discard_q |-> (slot_q == '0))
		else $error("discard pending with partial window");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(all_q) |-> all_q)
		else $error("ready flag fell");

endmodule

@@ src/acr_window_store.sv @@
// Per-channel three-slot sample windows and their medians.
// Depends on acr_pkg.
module acr_window_store import acr_pkg::*; #(
	parameter int CHANNEL_COUNT = 3,
	parameter int SAMPLE_BITS   = 10
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      advance,
	input  acr_wr_t                                   wr,
	input  logic [SAMPLE_W-1:0]                       sample,
	output logic [MEDIAN_CHANNELS-1:0][SAMPLE_W-1:0]  median
);

	localparam int KEEP_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

	logic [KEEP_BITS-1:0] value;
	logic [KEEP_BITS-1:0] store_q [CHANNEL_COUNT][SLOTS];

	assign value = sample[KEEP_BITS-1:0];

	// Write the kept sample into its slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
				for (int sl = 0; sl < SLOTS; sl++) begin
					store_q[ch][sl] <= '0;
				end
			end
		end else if (advance && wr.en) begin
			for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
				for (int sl = 0; sl < SLOTS; sl++) begin
					if (wr.chan == CHAN_W'(ch) && wr.slot == SLOT_W'(sl)) begin
						store_q[ch][sl] <= value;
					end
				end
			end
		end
	end

	// Medians over the window contents including this item's write
	for (genvar k = 0; k < MEDIAN_CHANNELS; k++) begin : g_med
		if (k < CHANNEL_COUNT) begin : g_on
			logic [KEEP_BITS-1:0] win [SLOTS];
			always_comb begin
				for (int sl = 0; sl < SLOTS; sl++) begin
					win[sl] = (wr.en && wr.chan == CHAN_W'(k) && wr.slot == SLOT_W'(sl))
						? value : store_q[k][sl];
				end
			end
			assign median[k] = med3(SAMPLE_W'(win[0]), SAMPLE_W'(win[1]),
				SAMPLE_W'(win[2]));
		end else begin : g_off
			assign median[k] = '0;
		end
	end

endmodule

@@ src/adc_channel_rotator_median3_core.sv @@
// Top level: converter channel rotator with median-of-three windows.
// Depends on acr_pkg, acr_scan_ctrl, acr_window_store.
//
//  channel | direction | signals                    | contents
//  s_*     | in        | tvalid tready tdata[15:0]  | one conversion result
//  m_*     | out       | tvalid tready tdata[39:0]  | mux input, three medians
//          |           | tuser[1:0]                 | kept flag, ready flag
//
// One item per cycle unless the output stalls: counters, window store and
// result register update at the accepting edge; the result is out next cycle.
// The result register decouples the sides: a new item is taken whenever the
// register is empty or is being emptied in the same cycle.
// Reset clears the counters, windows (medians read zero) and the valid flag.
module adc_channel_rotator_median3_core import acr_pkg::*; #(
	parameter int CHANNEL_COUNT = 3,
	parameter int SAMPLE_BITS   = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [2:0] mux_input, [12:3] median_first,
	                               // [22:13] median_second, [32:23] median_third,
	                               // [39:33] zero
	output logic [1:0]  m_tuser    // [0] sample_kept, [1] windows_ready
);

	logic                                     accept;
	acr_wr_t                                  wr;
	acr_status_t                              status;
	logic [MEDIAN_CHANNELS-1:0][SAMPLE_W-1:0] median;

	logic                                     valid_q;
	logic [MUX_W-1:0]                         mux_q;
	logic                                     kept_q;
	logic                                     ready_q;
	logic [MEDIAN_CHANNELS-1:0][SAMPLE_W-1:0] median_q;

	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	acr_scan_ctrl #(
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.wr     (wr),
		.status (status)
	);

	acr_window_store #(
		.CHANNEL_COUNT(CHANNEL_COUNT),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.wr     (wr),
		.sample (s_tdata[SAMPLE_W-1:0]),
		.median (median)
	);

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mux_q    <= MUX_BASE + MUX_W'(status.chan);
			kept_q   <= status.kept;
			ready_q  <= status.all_filled;
			median_q <= median;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, median_q[2], median_q[1], median_q[0], mux_q};
	assign m_tuser  = {ready_q, kept_q};

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted item produced no result");

	a_no_take_while_stuck: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !accept)
		else $error("item taken while result register blocked");

	a_mux_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] != 3'd1 && m_tdata[2:0] != 3'd2
			&& m_tdata[2:0] != 3'd3 && m_tdata[2:0] != 3'd4))
		else $error("mux input outside channel range");

endmodule

@@ bench/tb_adc_channel_rotator_median3_core.sv @@
// Self-checking bench for adc_channel_rotator_median3_core: a predictor of the scan
// and the median windows checks every output item. Depends on acr_pkg and the RTL.
module tb_adc_channel_rotator_median3_core;
	timeunit 1ns;
	timeprecision 1ps;
	import acr_pkg::*;

	localparam int NUM_CHANNELS    = 3;
	localparam int RANDOM_PER_RUN  = 406;
	localparam int IDLE_LIMIT      = 4000;
	localparam int SETTLE_CYCLES   = 10;

	// One expected output item
	typedef struct {
		logic [MUX_W-1:0]    mux_input;
		logic                sample_kept;
		logic [SAMPLE_W-1:0] median [MEDIAN_CHANNELS];
		logic                windows_ready;
	} scan_result_t;

	// Tracks the scan state and holds the output items still to come
	class median_scoreboard;
		logic [SAMPLE_W-1:0] windows [NUM_CHANNELS][SLOTS];
		int                  chan;
		int                  slot;
		logic                settling;
		logic                filled;
		scan_result_t        pending_results [$];
		int                  errors;

		function new();
			foreach (windows[c, s]) windows[c][s] = '0;
			chan     = 0;
			slot     = 0;
			settling = 1'b1;
			filled   = 1'b0;
			errors   = 0;
		endfunction

		function logic [SAMPLE_W-1:0] middle_of(input logic [SAMPLE_W-1:0] a,
				input logic [SAMPLE_W-1:0] b, input logic [SAMPLE_W-1:0] c);
			if ((a >= b && a <= c) || (a <= b && a >= c))
				return a;
			if ((b >= a && b <= c) || (b <= a && b >= c))
				return b;
			return c;
		endfunction

		// Apply one accepted sample and queue the item it must produce
		function void note_sample(input logic [SAMPLE_W-1:0] value);
			scan_result_t r;
			r.sample_kept = 1'b0;
			if (settling) begin
				settling = 1'b0;
			end else begin
				r.sample_kept = 1'b1;
				windows[chan][slot] = value;
				if (slot == SLOTS - 1) begin
					slot     = 0;
					settling = 1'b1;
					if (chan == NUM_CHANNELS - 1) begin
						chan   = 0;
						filled = 1'b1;
					end else begin
						chan = chan + 1;
					end
				end else begin
					slot = slot + 1;
				end
			end
			r.mux_input = MUX_BASE + MUX_W'(chan);
			for (int c = 0; c < MEDIAN_CHANNELS; c++)
				r.median[c] = (c < NUM_CHANNELS) ?
					middle_of(windows[c][0], windows[c][1], windows[c][2]) : '0;
			r.windows_ready = filled;
			pending_results.push_back(r);
		endfunction

		function void report_field(input string name, input logic [SAMPLE_W-1:0] expv,
				input logic [SAMPLE_W-1:0] actv);
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expv, actv);
		endfunction

		// Compare one accepted output item with the oldest expectation
		function void check_result(input logic [39:0] tdata, input logic [1:0] tuser);
			scan_result_t e;
			logic [SAMPLE_W-1:0] got_median [MEDIAN_CHANNELS];
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: expected none, actual tdata=%h tuser=%b",
					$time, tdata, tuser);
				return;
			end
			e = pending_results.pop_front();
			got_median[0] = tdata[12:3];
			got_median[1] = tdata[22:13];
			got_median[2] = tdata[32:23];
			if (tdata[2:0] !== e.mux_input)
				report_field("mux_input", SAMPLE_W'(e.mux_input), SAMPLE_W'(tdata[2:0]));
			if (tuser[0] !== e.sample_kept)
				report_field("sample_kept", SAMPLE_W'(e.sample_kept), SAMPLE_W'(tuser[0]));
			for (int c = 0; c < MEDIAN_CHANNELS; c++)
				if (got_median[c] !== e.median[c])
					report_field($sformatf("median[%0d]", c), e.median[c], got_median[c]);
			if (tuser[1] !== e.windows_ready)
				report_field("windows_ready", SAMPLE_W'(e.windows_ready),
					SAMPLE_W'(tuser[1]));
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata  = '0;   // [9:0] sample, [15:10] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;         // [2:0] mux_input, [12:3] median_first,
	                              // [22:13] median_second, [32:23] median_third
	logic [1:0]  m_tuser;         // [0] sample_kept, [1] windows_ready

	median_scoreboard   sb = new();
	int                 src_idle_pct   = 0;
	int                 sink_stall_pct = 0;
	int                 idle_cycles    = 0;
	logic [SAMPLE_W-1:0] last_sample   = '0;

	adc_channel_rotator_median3_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Check output items and stall the output at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Abort when no item moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Offer one sample after a random gap and hold it until taken
	task automatic send_sample(input logic [SAMPLE_W-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, value};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(value);
		last_sample = value;
	endtask

	// Hold off the input until every expected item has come out
	task automatic drain_outputs();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() > 0)
			@(posedge clk);
	endtask

	// Mostly uniform values, with extremes and repeats to hit median ties
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 12)
			return '0;
		if (roll < 24)
			return '1;
		if (roll < 36)
			return last_sample;
		return SAMPLE_W'($urandom_range(2**SAMPLE_W - 1));
	endfunction

	initial begin
		// Two full scans: settle drops, zero-filled medians early, ordering and ties
		logic [SAMPLE_W-1:0] directed [24] = '{
			10'd1,   10'd1023, 10'd0,    10'd512,
			10'd7,   10'd0,    10'd0,    10'd1023,
			10'd99,  10'd1023, 10'd1023, 10'd0,
			10'd1023, 10'h155, 10'h2AA,  10'h3FF,
			10'd0,   10'h2AA,  10'h155,  10'h000,
			10'h3FF, 10'd1,    10'd2,    10'd3
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_sample(directed[i]);
		drain_outputs();

		// Random scans under each idling mix
		for (int run = 0; run < 4; run++) begin
			case (run)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 77; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 77; end
				default: begin src_idle_pct = 35; sink_stall_pct = 35; end
			endcase
			repeat (RANDOM_PER_RUN)
				send_sample(pick_sample());
			drain_outputs();
		end

		sink_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
